[rtl/scrf_pkg.sv]
// ----------------------------------------------------------------------------
// Slider change report filter package
// Shared widths, command and reply codes, register indexes and the
// structures that pass between the top level, the slider lanes and the merge stage.
// ----------------------------------------------------------------------------
package scrf_pkg;

    // Channel configuration.
    localparam int NUM_CHANNELS  = 5;
    localparam int SLIDER_FIELDS = 5;
    localparam int NUM_LANES     = (NUM_CHANNELS < SLIDER_FIELDS) ? NUM_CHANNELS
                                                                  : SLIDER_FIELDS;

    // Field widths.
    localparam int VAL_W   = 11;
    localparam int THR_W   = 10;
    localparam int BURST_W = 8;
    localparam int CMD_W   = 2;
    localparam int REPLY_W = 2;
    localparam int MASK_W  = 5;
    localparam int CHAN_W  = 3;
    localparam int PCT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Percent scaling: value * 100 / 1024, saturated at 100.
    localparam int PCT_SHIFT = 10;
    localparam int PROD_W    = VAL_W + PCT_W;
    localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);
    localparam logic [PCT_W-1:0]  PCT_MAX   = PCT_W'(100);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_FRAME      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_HANDSHAKE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd2;

    // Reply codes.
    localparam logic [REPLY_W-1:0] REPLY_NONE      = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_HANDSHAKE = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_ACK       = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN = 2'd2;

    // Register reset values.
    localparam logic [THR_W-1:0]   SEND_THR_RST  = 10'd8;
    localparam logic [THR_W-1:0]   DISP_THR_RST  = 10'd14;
    localparam logic [BURST_W-1:0] BURST_LEN_RST = 8'd20;

    // Control broadcast from the top level to every lane.
    typedef struct packed {
        logic             frame_go;   // connected frame request accepted
        logic             seeded;     // anchors hold a seeded value
        logic             primed;     // a last-sent set exists
        logic [THR_W-1:0] send_thr;
        logic [THR_W-1:0] disp_thr;
    } lane_ctl_t;

    // What one lane found for the current frame.
    typedef struct packed {
        logic             changed;    // moved past the send threshold
        logic             moved;      // moved past the display threshold
        logic [PCT_W-1:0] pct;        // saturated percent of the value
    } lane_res_t;

    // Merged view of all lanes.
    typedef struct packed {
        logic              any_changed;
        logic [MASK_W-1:0] mask;
        logic [CHAN_W-1:0] chan;
        logic [PCT_W-1:0]  pct;
    } merge_res_t;

endpackage

[rtl/scrf_lane.sv]
// ----------------------------------------------------------------------------
// Slider lane
// Holds the anchor and last-sent value of one slider, compares the new
// value against both thresholds and computes its display percent.
// ----------------------------------------------------------------------------
module scrf_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scrf_pkg::lane_ctl_t        ctl,
    input  logic                       commit_send,
    input  logic [scrf_pkg::VAL_W-1:0] value,
    output scrf_pkg::lane_res_t        res
);
    import scrf_pkg::*;

    logic [VAL_W-1:0]  anchor_reg;
    logic [VAL_W-1:0]  last_sent_reg;
    logic [VAL_W-1:0]  anchor_eff;
    logic [VAL_W-1:0]  send_diff;
    logic [VAL_W-1:0]  disp_diff;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-PCT_SHIFT-1:0] pct_raw;

    // A frame that seeds the anchors compares against its own value.
    assign anchor_eff = ctl.seeded ? anchor_reg : value;

    // Absolute differences against the last-sent value and the anchor.
    assign send_diff = (value >= last_sent_reg) ? (value - last_sent_reg)
                                                : (last_sent_reg - value);
    assign disp_diff = (value >= anchor_eff) ? (value - anchor_eff)
                                             : (anchor_eff - value);

    // Percent of full scale, saturated for values above full scale.
    assign prod    = PROD_W'(value) * PCT_SCALE;
    assign pct_raw = prod[PROD_W-1:PCT_SHIFT];

    always_comb
    begin
        res.changed = ctl.primed && (send_diff > VAL_W'(ctl.send_thr));
        res.moved   = ctl.primed && (disp_diff > VAL_W'(ctl.disp_thr));
        res.pct     = (pct_raw > (PROD_W-PCT_SHIFT)'(PCT_MAX)) ? PCT_MAX
                                                               : pct_raw[PCT_W-1:0];
    end

    // Anchor and last-sent storage, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg    <= '0;
            last_sent_reg <= '0;
        end
        else
        begin
            if (ctl.frame_go && (!ctl.seeded || res.moved))
            begin
                anchor_reg <= value;
            end
            if (ctl.frame_go && commit_send)
            begin
                last_sent_reg <= value;
            end
        end
    end

endmodule

[rtl/scrf_merge.sv]
// ----------------------------------------------------------------------------
// Lane merge
// Combines the lane results into the display mask, the highest flagged
// channel with its percent, and the any-slider-changed flag.
// ----------------------------------------------------------------------------
module scrf_merge (
    input  scrf_pkg::lane_res_t  lane_res [scrf_pkg::NUM_LANES],
    output scrf_pkg::merge_res_t res
);
    import scrf_pkg::*;

    // The highest flagged lane wins the channel and percent fields.
    always_comb
    begin
        res = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (lane_res[i].changed)
            begin
                res.any_changed = 1'b1;
            end
            if (lane_res[i].moved)
            begin
                res.mask[i] = 1'b1;
                res.chan    = CHAN_W'(i);
                res.pct     = lane_res[i].pct;
            end
        end
    end

endmodule

[rtl/slider_change_report_filter_core.sv]
// ----------------------------------------------------------------------------
// Slider change report filter core
// The result of an accepted request is held in the output register. The
// block takes one request per cycle while out_ready does not stall it, the
// lanes and the merge being a single combinational stage ahead of that register.
// Reset clears the connection, burst and seeding state and loads the
// register defaults; slider storage is seeded by the first connected frame.
// ----------------------------------------------------------------------------
module slider_change_report_filter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scrf_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input request channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [scrf_pkg::CMD_W-1:0]      command,
    input  logic [scrf_pkg::VAL_W-1:0]      slider_0,
    input  logic [scrf_pkg::VAL_W-1:0]      slider_1,
    input  logic [scrf_pkg::VAL_W-1:0]      slider_2,
    input  logic [scrf_pkg::VAL_W-1:0]      slider_3,
    input  logic [scrf_pkg::VAL_W-1:0]      slider_4,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            send_frame,
    output logic [scrf_pkg::REPLY_W-1:0]    reply,
    output logic [scrf_pkg::MASK_W-1:0]     display_mask,
    output logic [scrf_pkg::CHAN_W-1:0]     display_channel,
    output logic [scrf_pkg::PCT_W-1:0]      display_percent
);
    import scrf_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0]   send_thr_reg;
    logic [THR_W-1:0]   disp_thr_reg;
    logic [BURST_W-1:0] burst_len_reg;

    // Connection and filter state.
    logic               connected_reg;
    logic [BURST_W-1:0] burst_left_reg;
    logic               last_sent_valid_reg;
    logic               anchor_seeded_reg;

    // Output register.
    logic               out_valid_reg;
    logic               send_frame_reg;
    logic [REPLY_W-1:0] reply_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [PCT_W-1:0]   pct_reg;

    logic               accept;
    logic               frame_go;
    logic               do_send;
    logic               send_frame_next;
    logic [REPLY_W-1:0] reply_next;
    logic [MASK_W-1:0]  mask_next;
    logic [CHAN_W-1:0]  chan_next;
    logic [PCT_W-1:0]   pct_next;

    logic [VAL_W-1:0]   slider_val [SLIDER_FIELDS];
    lane_ctl_t          lane_ctl;
    lane_res_t          lane_res [NUM_LANES];
    merge_res_t         merged;

    // Handshakes: a new request enters whenever the output register frees up.
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign frame_go  = accept && (command == CMD_FRAME) && connected_reg;

    assign slider_val[0] = slider_0;
    assign slider_val[1] = slider_1;
    assign slider_val[2] = slider_2;
    assign slider_val[3] = slider_3;
    assign slider_val[4] = slider_4;

    // Control shared by every lane.
    always_comb
    begin
        lane_ctl.frame_go = frame_go;
        lane_ctl.seeded   = anchor_seeded_reg;
        lane_ctl.primed   = last_sent_valid_reg;
        lane_ctl.send_thr = send_thr_reg;
        lane_ctl.disp_thr = disp_thr_reg;
    end

    // One lane per used slider.
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        scrf_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (lane_ctl),
            .commit_send (do_send),
            .value       (slider_val[g]),
            .res         (lane_res[g])
        );
    end

    scrf_merge u_merge (
        .lane_res (lane_res),
        .res      (merged)
    );

    // The first frame, a pending burst or a real change sends the frame.
    assign do_send = !last_sent_valid_reg || (burst_left_reg != '0) || merged.any_changed;

    // Result fields for the accepted request.
    always_comb
    begin
        send_frame_next = 1'b0;
        reply_next      = REPLY_NONE;
        mask_next       = '0;
        chan_next       = '0;
        pct_next        = '0;
        case (command)
            CMD_HANDSHAKE:
            begin
                reply_next = REPLY_HANDSHAKE;
            end
            CMD_DISCONNECT:
            begin
                reply_next = REPLY_ACK;
            end
            CMD_FRAME:
            begin
                if (connected_reg)
                begin
                    send_frame_next = do_send;
                    mask_next       = merged.mask;
                    chan_next       = merged.chan;
                    pct_next        = merged.pct;
                end
            end
            default:
            begin
                send_frame_next = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_thr_reg  <= SEND_THR_RST;
            disp_thr_reg  <= DISP_THR_RST;
            burst_len_reg <= BURST_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SEND_THR:  send_thr_reg  <= cfg_data;
                CFG_DISP_THR:  disp_thr_reg  <= cfg_data;
                CFG_BURST_LEN: burst_len_reg <= cfg_data[BURST_W-1:0];
                default:       send_thr_reg  <= send_thr_reg;
            endcase
        end
    end

    // Connection, burst and seeding state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg       <= 1'b0;
            burst_left_reg      <= '0;
            last_sent_valid_reg <= 1'b0;
            anchor_seeded_reg   <= 1'b0;
        end
        else if (accept)
        begin
            case (command)
                CMD_HANDSHAKE:
                begin
                    connected_reg  <= 1'b1;
                    burst_left_reg <= burst_len_reg;
                end
                CMD_DISCONNECT:
                begin
                    connected_reg <= 1'b0;
                end
                CMD_FRAME:
                begin
                    if (connected_reg)
                    begin
                        anchor_seeded_reg <= 1'b1;
                        if (last_sent_valid_reg && (burst_left_reg != '0))
                        begin
                            burst_left_reg <= burst_left_reg - 1'b1;
                        end
                        if (do_send)
                        begin
                            last_sent_valid_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    connected_reg <= connected_reg;
                end
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_frame_reg <= send_frame_next;
            reply_reg      <= reply_next;
            mask_reg       <= mask_next;
            chan_reg       <= chan_next;
            pct_reg        <= pct_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign send_frame      = send_frame_reg;
    assign reply           = reply_reg;
    assign display_mask    = mask_reg;
    assign display_channel = chan_reg;
    assign display_percent = pct_reg;

    // A reply never comes with a frame send or a display update.
    a_reply_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reply != REPLY_NONE) |-> !send_frame && (display_mask == '0))
        else $error("reply result carries frame or display fields");

    // An empty mask leaves the channel and percent at zero.
    a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (display_mask == '0) |-> (display_channel == '0) && (display_percent == '0))
        else $error("display fields set with an empty mask");

    // The channel is the highest bit set in the mask, and the percent saturates.
    a_highest_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (display_mask != '0)
            |-> ((display_mask >> display_channel) == MASK_W'(1)) && (display_percent <= PCT_MAX))
        else $error("display channel is not the highest flagged slider");

    // An accepted handshake leaves the block connected with the burst loaded.
    a_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == CMD_HANDSHAKE)
            |=> connected_reg && (burst_left_reg == $past(burst_len_reg)))
        else $error("handshake did not connect and load the burst counter");

endmodule
